// ===== design/sbh_pkg.sv =====
// Shared constants for the string bucket hash block.
// Used by the top level, the modulo unit, the port checker and the testbench; no dependencies.
package sbh_pkg;

    // Accumulator width and the fixed widths of the ports
    localparam int HASH_W    = 64;
    localparam int RAW_W     = 64;
    localparam int BUCKET_W  = 32;
    localparam int BYTE_W    = 8;
    localparam int DIV_CNT_W = $clog2(HASH_W + 1);

    // APB register map: one 32-bit register per word
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_HASH_MODE  = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    // Hash modes
    localparam logic MODE_OAAT   = 1'b0;
    localparam logic MODE_SIMPLE = 1'b1;

    localparam logic [BUCKET_W-1:0] TABLE_SIZE_RESET = BUCKET_W'(65536);

endpackage

// ===== design/sbh_divider.sv =====
// Bit-serial restoring modulo unit: HASH_W-bit dividend, 32-bit divisor.
// Depends on sbh_pkg. A zero divisor yields a remainder of zero.
module sbh_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sbh_pkg::HASH_W-1:0]      dividend,
    input  logic [sbh_pkg::BUCKET_W-1:0]    divisor,
    output logic                            done,
    output logic [sbh_pkg::BUCKET_W-1:0]    remainder
);
    import sbh_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [HASH_W-1:0]      dvd_reg, dvd_next;
    logic [BUCKET_W-1:0]    dsr_reg, dsr_next;
    logic [BUCKET_W-1:0]    rem_reg, rem_next;
    logic [BUCKET_W:0]      trial;
    logic [BUCKET_W:0]      diff;
    logic                   fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(HASH_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = (dsr_reg == '0) ? '0 : rem_reg;

endmodule

// ===== design/string_bucket_hash_unit.sv =====
// Byte-serial string hash (one-at-a-time or shift-by-8) with bucket reduction.
// Depends on sbh_pkg and sbh_divider; APB register port for mode and table size.
// Each key byte is accepted in idle, then takes three ALU passes in one-at-a-time
// mode or one in simple mode; no new byte is accepted until idle again. Last byte:
// final mix (one-at-a-time only), 64 modulo steps, output register; an empty key
// goes straight to the output. rst_n clears control and reloads the registers.
module string_bucket_hash_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sbh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sbh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // key byte channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sbh_pkg::BYTE_W-1:0]       key_byte,
    input  logic                             last_byte,
    input  logic                             empty_key,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sbh_pkg::BUCKET_W-1:0]     bucket_index,
    output logic [sbh_pkg::RAW_W-1:0]        raw_hash
);
    import sbh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_ADD,
        ST_MIX_SHL,
        ST_MIX_SHR,
        ST_FIN_SHL3,
        ST_FIN_SHR11,
        ST_FIN_SHL15,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic                   mode_reg;
    logic [BUCKET_W-1:0]    table_size_reg;
    logic [HASH_W-1:0]      acc_reg, acc_next;
    logic [HASH_W-1:0]      byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic [HASH_W-1:0]      hash_reg, hash_next;
    logic [BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]      out_hash_reg, out_hash_next;
    logic [BUCKET_W-1:0]    out_bucket_reg, out_bucket_next;

    logic                   alu_xor;
    logic [HASH_W-1:0]      alu_a, alu_b, alu_res;
    logic                   div_start;
    logic                   div_done;
    logic [BUCKET_W-1:0]    div_rem;
    logic                   cfg_write;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OAAT;
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_HASH_MODE)
                mode_reg <= pwdata[0];
            else
                table_size_reg <= pwdata[BUCKET_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? APB_DATA_W'(table_size_reg)
                                                 : APB_DATA_W'(mode_reg);

    // Shared add/xor unit; the sequencer picks its operands each cycle
    always_comb
    begin
        alu_xor = 1'b0;
        alu_a   = acc_reg;
        alu_b   = '0;
        case (state_reg)
            ST_MIX_ADD:
            begin
                alu_a = (mode_reg == MODE_SIMPLE) ? (acc_reg << 8) : acc_reg;
                alu_b = byte_reg;
            end
            ST_MIX_SHL:   alu_b = acc_reg << 10;
            ST_MIX_SHR:
            begin
                alu_xor = 1'b1;
                alu_b   = acc_reg >> 6;
            end
            ST_FIN_SHL3:  alu_b = acc_reg << 3;
            ST_FIN_SHR11:
            begin
                alu_xor = 1'b1;
                alu_b   = acc_reg >> 11;
            end
            ST_FIN_SHL15: alu_b = acc_reg << 15;
            default:      alu_b = '0;
        endcase
    end

    assign alu_res = alu_xor ? (alu_a ^ alu_b) : (alu_a + alu_b);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        hash_next       = hash_reg;
        bucket_next     = bucket_reg;
        out_valid_next  = out_valid_reg;
        out_hash_next   = out_hash_reg;
        out_bucket_next = out_bucket_reg;
        div_start       = 1'b0;

        // drop the held result once it is taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (empty_key)
                    begin
                        acc_next    = '0;
                        hash_next   = '0;
                        bucket_next = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        byte_next  = {{(HASH_W-BYTE_W){key_byte[BYTE_W-1]}}, key_byte};
                        last_next  = last_byte;
                        state_next = ST_MIX_ADD;
                    end
                end
            end
            ST_MIX_ADD:
            begin
                acc_next = alu_res;
                if (mode_reg == MODE_SIMPLE)
                begin
                    if (last_reg)
                    begin
                        hash_next  = alu_res;
                        acc_next   = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_MIX_SHL;
            end
            ST_MIX_SHL:
            begin
                acc_next   = alu_res;
                state_next = ST_MIX_SHR;
            end
            ST_MIX_SHR:
            begin
                acc_next   = alu_res;
                state_next = last_reg ? ST_FIN_SHL3 : ST_IDLE;
            end
            ST_FIN_SHL3:
            begin
                acc_next   = alu_res;
                state_next = ST_FIN_SHR11;
            end
            ST_FIN_SHR11:
            begin
                acc_next   = alu_res;
                state_next = ST_FIN_SHL15;
            end
            ST_FIN_SHL15:
            begin
                hash_next  = alu_res;
                acc_next   = '0;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    bucket_next = div_rem;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_hash_next   = hash_reg;
                    out_bucket_next = bucket_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        hash_reg       <= hash_next;
        bucket_reg     <= bucket_next;
        out_hash_reg   <= out_hash_next;
        out_bucket_reg <= out_bucket_next;
    end

    // Modulo reduction by the configured table size
    sbh_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (alu_res),
        .divisor   (table_size_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign raw_hash     = RAW_W'(out_hash_reg);
    assign bucket_index = out_bucket_reg;

endmodule

// ===== design/sbh_checker.sv =====
// Port-level checks for string_bucket_hash_unit, attached by bind.
// Depends on sbh_pkg for port widths.
module sbh_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pready,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [sbh_pkg::BUCKET_W-1:0]     bucket_index,
    input  logic [sbh_pkg::RAW_W-1:0]        raw_hash
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_hash) && $stable(bucket_index))
        else $error("stalled result changed or dropped");

    // A zero hash always lands in bucket zero
    a_zero_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (raw_hash == '0) |-> (bucket_index == '0))
        else $error("zero hash with nonzero bucket");

    // The sequencer is busy right after taking a key byte
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held high after an accepted transaction");

    // The register port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind string_bucket_hash_unit sbh_checker u_sbh_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for string_bucket_hash_unit: streams key bytes, predicts
// the raw hash and bucket index of every key, and compares each result transaction.
// Depends on sbh_pkg and the string_bucket_hash_unit RTL.
`timescale 1ns / 100ps

module testbench;

    import sbh_pkg::*;

    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [BUCKET_W-1:0] bucket_index;
        logic [RAW_W-1:0]    raw_hash;
    } bucket_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     key_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  empty_key = 1'b0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BUCKET_W-1:0]   bucket_index;
    logic [RAW_W-1:0]      raw_hash;

    // Shadow copy of the block's state and registers
    logic [HASH_W-1:0]     shadow_acc = '0;
    logic                  shadow_mode = MODE_OAAT;
    logic [BUCKET_W-1:0]   shadow_table_size = TABLE_SIZE_RESET;

    bucket_result_t        pending_buckets[$];
    int                    error_count = 0;
    int                    random_items = 0;
    logic                  calm_traffic = 1'b0;

    string_bucket_hash_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_byte     (key_byte),
        .last_byte    (last_byte),
        .empty_key    (empty_key),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_index (bucket_index),
        .raw_hash     (raw_hash)
    );

    always #10 clk = ~clk;

    // Mix one sign-extended key byte into the accumulator
    function automatic logic [HASH_W-1:0] mix_key_byte(input logic [HASH_W-1:0] h,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic mode);
        logic [HASH_W-1:0] ext;
        ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        if (mode == MODE_SIMPLE)
            return (h << 8) + ext;
        h = h + ext;
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    // Apply the end-of-key avalanche (one-at-a-time mode only)
    function automatic logic [HASH_W-1:0] finalize_hash(input logic [HASH_W-1:0] h,
                                                        input logic mode);
        if (mode == MODE_SIMPLE)
            return h;
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // Advance the shadow state by one accepted transaction; queue a result at key end
    function automatic void predict_bucket(input logic [BYTE_W-1:0] b, input logic last,
                                           input logic empty);
        bucket_result_t res;
        logic [HASH_W-1:0] h;
        if (empty) begin
            h = '0;
        end
        else begin
            shadow_acc = mix_key_byte(shadow_acc, b, shadow_mode);
            if (!last)
                return;
            h = finalize_hash(shadow_acc, shadow_mode);
        end
        shadow_acc = '0;
        res.raw_hash = h;
        if (shadow_table_size == '0)
            res.bucket_index = '0;
        else
            res.bucket_index = BUCKET_W'(h % {32'b0, shadow_table_size});
        pending_buckets.push_back(res);
    endfunction

    // Drive one key-byte transaction and wait until it is accepted
    task automatic send_key_item(input logic [BYTE_W-1:0] b, input logic last,
                                 input logic empty);
        @(negedge clk);
        if (!calm_traffic && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        key_byte  <= b;
        last_byte <= last;
        empty_key <= empty;
        do
            @(posedge clk);
        while (!in_ready);
        predict_bucket(b, last, empty);
    endtask

    // Send a whole key of random bytes, last marker on the final one
    task automatic send_random_key(input int len);
        for (int i = 0; i < len; i++) begin
            send_key_item(8'($urandom), i == len - 1, 1'b0);
            random_items++;
        end
    endtask

    // Drop valid, wait for all results, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_config(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == REG_HASH_MODE)
            shadow_mode = value[0];
        else
            shadow_table_size = value[BUCKET_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver stalls at random outside calm stretches
    always @(negedge clk)
        out_ready <= calm_traffic || ($urandom_range(99) >= 9);

    // Compare each result transaction with the oldest prediction
    always @(posedge clk) begin
        bucket_result_t exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (pending_buckets.size() == 0) begin
                $error("unexpected result: bucket_index %0h raw_hash %0h",
                       bucket_index, raw_hash);
                error_count++;
            end
            else begin
                exp_res = pending_buckets.pop_front();
                if (bucket_index !== exp_res.bucket_index) begin
                    $error("bucket_index: expected %0h, got %0h",
                           exp_res.bucket_index, bucket_index);
                    error_count++;
                end
                if (raw_hash !== exp_res.raw_hash) begin
                    $error("raw_hash: expected %0h, got %0h", exp_res.raw_hash, raw_hash);
                    error_count++;
                end
            end
        end
    end

    // Keys hashed with the reset configuration
    task automatic test_reset_defaults();
        send_key_item(8'h61, 1'b1, 1'b0);
        send_key_item(8'h6b, 1'b0, 1'b0);
        send_key_item(8'h65, 1'b0, 1'b0);
        send_key_item(8'h79, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Single-byte keys at the sign boundary of the byte
    task automatic test_byte_extremes();
        send_key_item(8'h00, 1'b1, 1'b0);
        send_key_item(8'h7f, 1'b1, 1'b0);
        send_key_item(8'h80, 1'b1, 1'b0);
        send_key_item(8'hff, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Empty keys: alone, with last set, and discarding a partial key
    task automatic test_empty_key();
        send_key_item(8'hff, 1'b0, 1'b1);
        send_key_item(8'h5a, 1'b1, 1'b1);
        send_key_item(8'h41, 1'b0, 1'b0);
        send_key_item(8'h42, 1'b0, 1'b0);
        send_key_item(8'h00, 1'b0, 1'b1);
        send_key_item(8'h43, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Shift-by-8 mode, with a key long enough to shift bytes out the top
    task automatic test_simple_mode();
        write_config(REG_HASH_MODE, 32'(MODE_SIMPLE));
        for (int i = 0; i < 10; i++)
            send_key_item(8'hff - 8'(i * 16), i == 9, 1'b0);
        wait_idle();
    endtask

    // Extreme table sizes, zero among them
    task automatic test_table_sizes();
        write_config(REG_TABLE_SIZE, 32'hffff_ffff);
        send_key_item(8'h9c, 1'b1, 1'b0);
        wait_idle();
        write_config(REG_TABLE_SIZE, 32'd1);
        send_key_item(8'h33, 1'b1, 1'b0);
        wait_idle();
        write_config(REG_TABLE_SIZE, 32'd0);
        send_key_item(8'hc7, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Mode changed between bytes of one key; final mix follows the last byte's mode
    task automatic test_mode_switch_mid_key();
        write_config(REG_TABLE_SIZE, 32'd1009);
        write_config(REG_HASH_MODE, 32'(MODE_OAAT));
        send_key_item(8'h12, 1'b0, 1'b0);
        wait_idle();
        write_config(REG_HASH_MODE, 32'(MODE_SIMPLE));
        send_key_item(8'hab, 1'b1, 1'b0);
        send_key_item(8'h34, 1'b0, 1'b0);
        wait_idle();
        write_config(REG_HASH_MODE, 32'(MODE_OAAT));
        send_key_item(8'hcd, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Phases of random keys, each under a fresh random configuration
    task automatic test_random_traffic();
        int phase = 0;
        int start;
        int kind;
        logic [APB_DATA_W-1:0] size;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(5))
                0: size = 32'd1;
                1: size = 32'hffff_ffff;
                2: size = $urandom;
                3: size = $urandom_range(1000, 2);
                4: size = 32'd1 << $urandom_range(31);
                default: size = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(97, 3);
            endcase
            write_config(REG_TABLE_SIZE, size);
            write_config(REG_HASH_MODE, 32'($urandom_range(1)));
            // hold one phase free of any stalls on both sides
            calm_traffic = (phase == 3);
            start = random_items;
            while (random_items - start < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
                kind = $urandom_range(99);
                if (kind < 6) begin
                    send_key_item(8'($urandom), 1'($urandom), 1'b1);
                    random_items++;
                end
                else if (kind < 10) begin
                    // broken key: a few bytes, then an empty key drops them
                    for (int i = $urandom_range(4, 1); i > 0; i--) begin
                        send_key_item(8'($urandom), 1'b0, 1'b0);
                        random_items++;
                    end
                    send_key_item(8'($urandom), 1'($urandom), 1'b1);
                    random_items++;
                end
                else if (kind < 25) begin
                    send_random_key($urandom_range(24, 9));
                end
                else begin
                    send_random_key($urandom_range(8, 1));
                end
            end
            wait_idle();
            calm_traffic = 1'b0;
            phase++;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_reset_defaults();
        test_byte_extremes();
        test_empty_key();
        test_simple_mode();
        test_table_sizes();
        test_mode_switch_mid_key();
        test_random_traffic();

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sbh_pkg.sv
design/sbh_divider.sv
design/string_bucket_hash_unit.sv
design/sbh_checker.sv
tb/sv/testbench.sv
